/* sv/bfga_pkg.sv */
// Shared types, constants and helpers for the best-fit granule allocator.
`timescale 1ns / 1ps
package bfga_pkg;

	localparam int GRANULES  = 4096;
	localparam int GRAN_W    = 12;
	localparam int LEN_W     = 13;
	localparam int OCC_BITS  = 64;
	localparam int OCC_IDX_W = 6;
	localparam int OCC_WORDS = GRANULES / OCC_BITS;
	localparam int OCC_WA_W  = GRAN_W - OCC_IDX_W;

	localparam logic [LEN_W-1:0] LINK_NIL  = LEN_W'(GRANULES);
	localparam logic [LEN_W-1:0] POOL_LEN  = LEN_W'(GRANULES);
	localparam logic [4:0]       LOG2_RST  = 5'd8;
	localparam logic             ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_BAD_SIZE = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic        action;
		logic [31:0] request_bytes;
		logic [11:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] block_offset;
		logic [12:0] block_granules;
		logic [12:0] free_granules;
	} rsp_t;

	// datapath micro-operations, one per controller step
	typedef enum logic [4:0] {
		OP_NONE    = 5'd0,
		OP_CLR     = 5'd1,
		OP_LOAD    = 5'd2,
		OP_A_CHK   = 5'd3,
		OP_A_W1    = 5'd4,
		OP_A_W2    = 5'd5,
		OP_A_HEAD  = 5'd6,
		OP_A_REC   = 5'd7,
		OP_A_SPLIT = 5'd8,
		OP_A_MARK  = 5'd9,
		OP_A_FIN   = 5'd10,
		OP_F_CHK   = 5'd11,
		OP_F_RREC  = 5'd12,
		OP_F_RMRG  = 5'd13,
		OP_F_LEFT  = 5'd14,
		OP_F_LREC  = 5'd15,
		OP_F_LMRG  = 5'd16,
		OP_F_FINAL = 5'd17,
		OP_U0      = 5'd18,
		OP_U1      = 5'd19,
		OP_P0      = 5'd20,
		OP_P1      = 5'd21,
		OP_OUT     = 5'd22
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic req_free;
		logic size_bad;
		logic word_hit;
		logic sum_hit;
		logic do_split;
		logic free_ok;
		logic r_in_pool;
		logic rec_free;
		logic b_nonzero;
		logic out_free;
	} dp_status_t;

	// index of the lowest set bit
	function automatic logic [OCC_IDX_W-1:0] ffs64(input logic [OCC_BITS-1:0] v);
		logic [OCC_IDX_W-1:0] idx;
		idx = '0;
		for (int i = OCC_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = OCC_IDX_W'(i);
		end
		return idx;
	endfunction

endpackage

/* sv/bfga_ctrl.sv */
// Sequencer for the allocator: steps the datapath through allocate and free.
`timescale 1ns / 1ps
module bfga_ctrl import bfga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [21:0] {
		S_INIT    = 22'h000001,
		S_IDLE    = 22'h000002,
		S_A_CHK   = 22'h000004,
		S_A_W1    = 22'h000008,
		S_A_W2    = 22'h000010,
		S_A_HEAD  = 22'h000020,
		S_A_REC   = 22'h000040,
		S_A_SPLIT = 22'h000080,
		S_A_MARK  = 22'h000100,
		S_A_FIN   = 22'h000200,
		S_F_CHK   = 22'h000400,
		S_F_RREC  = 22'h000800,
		S_F_RMRG  = 22'h001000,
		S_F_LEFT  = 22'h002000,
		S_F_LREC  = 22'h004000,
		S_F_LMRG  = 22'h008000,
		S_F_FINAL = 22'h010000,
		S_U0      = 22'h020000,
		S_U1      = 22'h040000,
		S_P0      = 22'h080000,
		S_P1      = 22'h100000,
		S_DONE    = 22'h200000
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_CLR;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = st.req_free ? S_F_CHK : S_A_CHK;
				end
			end
			S_A_CHK: begin
				cmd.op  = OP_A_CHK;
				state_d = st.size_bad ? S_DONE : S_A_W1;
			end
			S_A_W1: begin
				cmd.op = OP_A_W1;
				if (st.word_hit) state_d = S_A_HEAD;
				else if (st.sum_hit) state_d = S_A_W2;
				else state_d = S_DONE;
			end
			S_A_W2: begin
				cmd.op  = OP_A_W2;
				state_d = S_A_HEAD;
			end
			S_A_HEAD: begin
				cmd.op  = OP_A_HEAD;
				state_d = S_A_REC;
			end
			S_A_REC: begin
				cmd.op  = OP_A_REC;
				state_d = S_U0;
				ret_d   = S_A_SPLIT;
			end
			S_A_SPLIT: begin
				cmd.op  = OP_A_SPLIT;
				state_d = S_A_MARK;
			end
			S_A_MARK: begin
				cmd.op = OP_A_MARK;
				if (st.do_split) begin
					state_d = S_P0;
					ret_d   = S_A_FIN;
				end else begin
					state_d = S_A_FIN;
				end
			end
			S_A_FIN: begin
				cmd.op  = OP_A_FIN;
				state_d = S_DONE;
			end
			S_F_CHK: begin
				cmd.op = OP_F_CHK;
				if (!st.free_ok) state_d = S_DONE;
				else if (st.r_in_pool) state_d = S_F_RREC;
				else state_d = S_F_LEFT;
			end
			S_F_RREC: begin
				cmd.op = OP_F_RREC;
				if (st.rec_free) begin
					state_d = S_U0;
					ret_d   = S_F_RMRG;
				end else begin
					state_d = S_F_LEFT;
				end
			end
			S_F_RMRG: begin
				cmd.op  = OP_F_RMRG;
				state_d = S_F_LEFT;
			end
			S_F_LEFT: begin
				cmd.op  = OP_F_LEFT;
				state_d = st.b_nonzero ? S_F_LREC : S_F_FINAL;
			end
			S_F_LREC: begin
				cmd.op = OP_F_LREC;
				if (st.rec_free) begin
					state_d = S_U0;
					ret_d   = S_F_LMRG;
				end else begin
					state_d = S_F_FINAL;
				end
			end
			S_F_LMRG: begin
				cmd.op  = OP_F_LMRG;
				state_d = S_F_FINAL;
			end
			S_F_FINAL: begin
				cmd.op  = OP_F_FINAL;
				state_d = S_P0;
				ret_d   = S_DONE;
			end
			S_U0: begin
				cmd.op  = OP_U0;
				state_d = S_U1;
			end
			S_U1: begin
				cmd.op  = OP_U1;
				state_d = ret_q;
			end
			S_P0: begin
				cmd.op  = OP_P0;
				state_d = S_P1;
			end
			S_P1: begin
				cmd.op  = OP_P1;
				state_d = ret_q;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_DONE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

/* sv/bfga_dp.sv */
// Allocator datapath: block and free-list memories, class bitmap, result register.
`timescale 1ns / 1ps
module bfga_dp import bfga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	input  req_t       req,
	input  logic       cfg_valid,
	input  logic [4:0] cfg_data,
	output rsp_t       rsp,
	output logic       rsp_valid,
	input  logic       rsp_ready
);

	// per-granule block records and free-list links
	logic [LEN_W-1:0]   len_mem   [GRANULES];
	logic               beg_mem   [GRANULES];
	logic               busy_mem  [GRANULES];
	logic [GRAN_W-1:0]  left_mem  [GRANULES];
	logic [LEN_W-1:0]   next_mem  [GRANULES];
	logic [LEN_W-1:0]   prev_mem  [GRANULES];
	logic [GRAN_W-1:0]  head_mem  [GRANULES];
	logic [OCC_BITS-1:0] occ_mem  [OCC_WORDS];

	logic                len_we, beg_we, busy_we, left_we, next_we, prev_we, head_we, occ_we;
	logic [GRAN_W-1:0]   len_wa, beg_wa, busy_wa, left_wa, next_wa, prev_wa, head_wa;
	logic [OCC_WA_W-1:0] occ_wa, occ_ra;
	logic [LEN_W-1:0]    len_wd, next_wd, prev_wd;
	logic                beg_wd, busy_wd;
	logic [GRAN_W-1:0]   left_wd, head_wd;
	logic [OCC_BITS-1:0] occ_wd;
	logic [GRAN_W-1:0]   rec_ra, head_ra;

	logic [LEN_W-1:0]    len_rd, next_rd, prev_rd;
	logic                beg_rd, busy_rd;
	logic [GRAN_W-1:0]   left_rd, head_rd;
	logic [OCC_BITS-1:0] occ_rd;

	logic [4:0]          log2_q;
	logic [GRAN_W-1:0]   clr_q;
	logic [OCC_BITS-1:0] sum_q;
	logic [LEN_W-1:0]    total_q;
	logic [LEN_W-1:0]    need_q, blen_q, tlen_q, tnext_q, tprev_q;
	logic                bad_q;
	logic [GRAN_W-1:0]   b_q, l_q, r_q, cls_q, tgt_q;
	logic [1:0]          res_status_q;
	logic [GRAN_W-1:0]   res_off_q;
	logic [LEN_W-1:0]    res_len_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	// request rounding to granules
	logic [32:0] round_sum, round_g;
	logic        req_bad;
	assign round_sum = {1'b0, req.request_bytes} + ((33'd1 << log2_q) - 33'd1);
	assign round_g   = round_sum >> log2_q;
	assign req_bad   = (req.request_bytes == 32'd0) || (round_g > 33'(GRANULES));

	// class search
	logic [GRAN_W-1:0]    need_cls;
	logic [OCC_BITS-1:0]  word_hits, sum_hits;
	assign need_cls  = GRAN_W'(need_q - LEN_W'(1));
	assign word_hits = occ_rd & ({OCC_BITS{1'b1}} << need_cls[OCC_IDX_W-1:0]);
	assign sum_hits  = sum_q & (({OCC_BITS{1'b1}} << need_cls[GRAN_W-1:OCC_IDX_W]) << 1);

	logic [GRAN_W-1:0] cls_w1, cls_w2;
	assign cls_w1 = {need_cls[GRAN_W-1:OCC_IDX_W], ffs64(word_hits)};
	assign cls_w2 = {cls_q[GRAN_W-1:OCC_IDX_W], ffs64(occ_rd)};

	// list target class and its bitmap bit
	logic [GRAN_W-1:0]   t_cls;
	logic [OCC_BITS-1:0] t_bit;
	logic                t_occ;
	assign t_cls = GRAN_W'(tlen_q - LEN_W'(1));
	assign t_bit = OCC_BITS'(1) << t_cls[OCC_IDX_W-1:0];
	assign t_occ = |(occ_rd & t_bit);

	// neighbor arithmetic
	logic [LEN_W-1:0] chk_end, mrg_len, mrg_end, lmrg_end, split_end, rem_len;
	logic             split;
	assign chk_end   = {1'b0, b_q} + len_rd;
	assign mrg_len   = blen_q + tlen_q;
	assign mrg_end   = {1'b0, b_q} + mrg_len;
	assign lmrg_end  = {1'b0, l_q} + mrg_len;
	assign split_end = {1'b0, b_q} + blen_q;
	assign rem_len   = blen_q - need_q;
	assign split     = blen_q > need_q;

	assign st.clr_done  = (clr_q == GRAN_W'(GRANULES - 1));
	assign st.req_free  = (req.action == ACT_FREE);
	assign st.size_bad  = bad_q;
	assign st.word_hit  = |word_hits;
	assign st.sum_hit   = |sum_hits;
	assign st.do_split  = split;
	assign st.free_ok   = beg_rd && busy_rd;
	assign st.r_in_pool = !chk_end[LEN_W-1];
	assign st.rec_free  = !busy_rd;
	assign st.b_nonzero = (b_q != '0);
	assign st.out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		len_we = 1'b0;  len_wa = '0;  len_wd = '0;
		beg_we = 1'b0;  beg_wa = '0;  beg_wd = 1'b0;
		busy_we = 1'b0; busy_wa = '0; busy_wd = 1'b0;
		left_we = 1'b0; left_wa = '0; left_wd = '0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		head_we = 1'b0; head_wa = '0; head_wd = '0;
		occ_we = 1'b0;  occ_wa = '0;  occ_wd = '0;
		rec_ra  = req.release_offset;
		head_ra = '0;
		occ_ra  = '0;
		case (cmd.op)
			OP_CLR: begin
				beg_we = 1'b1; beg_wa = clr_q; beg_wd = (clr_q == '0);
				if (clr_q == '0) begin
					len_we = 1'b1;  len_wa = '0;  len_wd = POOL_LEN;
					busy_we = 1'b1; busy_wa = '0; busy_wd = 1'b0;
					next_we = 1'b1; next_wa = '0; next_wd = LINK_NIL;
					prev_we = 1'b1; prev_wa = '0; prev_wd = LINK_NIL;
					head_we = 1'b1; head_wa = GRAN_W'(GRANULES - 1); head_wd = '0;
				end
				if (clr_q < GRAN_W'(OCC_WORDS)) begin
					occ_we = 1'b1;
					occ_wa = clr_q[OCC_WA_W-1:0];
					occ_wd = (clr_q == GRAN_W'(OCC_WORDS - 1)) ?
						(OCC_BITS'(1) << (OCC_BITS - 1)) : '0;
				end
			end
			OP_A_CHK: occ_ra = need_cls[GRAN_W-1:OCC_IDX_W];
			OP_A_W1: begin
				head_ra = cls_w1;
				occ_ra  = OCC_WA_W'(ffs64(sum_hits));
			end
			OP_A_W2: head_ra = cls_w2;
			OP_A_HEAD: rec_ra = head_rd;
			OP_A_SPLIT: begin
				if (split) begin
					len_we = 1'b1;  len_wa = b_q + need_q[GRAN_W-1:0]; len_wd = rem_len;
					beg_we = 1'b1;  beg_wa = len_wa; beg_wd = 1'b1;
					busy_we = 1'b1; busy_wa = len_wa; busy_wd = 1'b0;
					left_we = 1'b1; left_wa = len_wa; left_wd = b_q;
				end
			end
			OP_A_MARK: begin
				busy_we = 1'b1; busy_wa = b_q; busy_wd = 1'b1;
				if (split) begin
					len_we = 1'b1; len_wa = b_q; len_wd = need_q;
					if (!split_end[LEN_W-1]) begin
						left_we = 1'b1; left_wa = split_end[GRAN_W-1:0]; left_wd = r_q;
					end
				end
			end
			OP_F_CHK: begin
				rec_ra = chk_end[GRAN_W-1:0];
				if (beg_rd && busy_rd) begin
					busy_we = 1'b1; busy_wa = b_q; busy_wd = 1'b0;
				end
			end
			OP_F_RMRG: begin
				beg_we = 1'b1; beg_wa = tgt_q; beg_wd = 1'b0;
				if (!mrg_end[LEN_W-1]) begin
					left_we = 1'b1; left_wa = mrg_end[GRAN_W-1:0]; left_wd = b_q;
				end
			end
			OP_F_LEFT: rec_ra = l_q;
			OP_F_LMRG: begin
				beg_we = 1'b1; beg_wa = b_q; beg_wd = 1'b0;
				if (!lmrg_end[LEN_W-1]) begin
					left_we = 1'b1; left_wa = lmrg_end[GRAN_W-1:0]; left_wd = l_q;
				end
			end
			OP_F_FINAL: begin
				len_we = 1'b1; len_wa = b_q; len_wd = blen_q;
			end
			OP_U0: begin
				if (!tnext_q[LEN_W-1]) begin
					prev_we = 1'b1; prev_wa = tnext_q[GRAN_W-1:0]; prev_wd = tprev_q;
				end
				if (!tprev_q[LEN_W-1]) begin
					next_we = 1'b1; next_wa = tprev_q[GRAN_W-1:0]; next_wd = tnext_q;
				end
				head_ra = t_cls;
				occ_ra  = t_cls[GRAN_W-1:OCC_IDX_W];
			end
			OP_U1: begin
				if (t_occ && (head_rd == tgt_q)) begin
					head_we = 1'b1; head_wa = t_cls; head_wd = tnext_q[GRAN_W-1:0];
					if (tnext_q == LINK_NIL) begin
						occ_we = 1'b1;
						occ_wa = t_cls[GRAN_W-1:OCC_IDX_W];
						occ_wd = occ_rd & ~t_bit;
					end
				end
			end
			OP_P0: begin
				prev_we = 1'b1; prev_wa = tgt_q; prev_wd = LINK_NIL;
				head_ra = t_cls;
				occ_ra  = t_cls[GRAN_W-1:OCC_IDX_W];
			end
			OP_P1: begin
				next_we = 1'b1; next_wa = tgt_q;
				next_wd = t_occ ? {1'b0, head_rd} : LINK_NIL;
				if (t_occ) begin
					prev_we = 1'b1; prev_wa = head_rd; prev_wd = {1'b0, tgt_q};
				end
				head_we = 1'b1; head_wa = t_cls; head_wd = tgt_q;
				occ_we = 1'b1;
				occ_wa = t_cls[GRAN_W-1:OCC_IDX_W];
				occ_wd = occ_rd | t_bit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_wa] <= len_wd;
		len_rd <= len_mem[rec_ra];
		if (beg_we) beg_mem[beg_wa] <= beg_wd;
		beg_rd <= beg_mem[rec_ra];
		if (busy_we) busy_mem[busy_wa] <= busy_wd;
		busy_rd <= busy_mem[rec_ra];
		if (left_we) left_mem[left_wa] <= left_wd;
		left_rd <= left_mem[rec_ra];
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd <= next_mem[rec_ra];
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd <= prev_mem[rec_ra];
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		occ_rd <= occ_mem[occ_ra];
	end

	// control state: config, sweep counter, summary bits, totals, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q      <= LOG2_RST;
			clr_q       <= '0;
			sum_q       <= OCC_BITS'(1) << (OCC_BITS - 1);
			total_q     <= POOL_LEN;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) log2_q <= cfg_data;
			if (cmd.op == OP_CLR) clr_q <= clr_q + GRAN_W'(1);
			if (occ_we && (cmd.op != OP_CLR))
				sum_q[occ_wa] <= |occ_wd;
			if (cmd.op == OP_A_FIN) total_q <= total_q - need_q;
			if ((cmd.op == OP_F_CHK) && beg_rd && busy_rd) total_q <= total_q + len_rd;
			if (cmd.op == OP_OUT) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				need_q <= round_g[LEN_W-1:0];
				bad_q  <= req_bad;
				b_q    <= req.release_offset;
			end
			OP_A_CHK: begin
				res_status_q <= ST_BAD_SIZE;
				res_off_q    <= '0;
				res_len_q    <= '0;
			end
			OP_A_W1: begin
				cls_q <= st.word_hit ? cls_w1 :
					{OCC_WA_W'(ffs64(sum_hits)), {OCC_IDX_W{1'b0}}};
				res_status_q <= ST_NO_FIT;
				res_off_q    <= '0;
				res_len_q    <= '0;
			end
			OP_A_HEAD: b_q <= head_rd;
			OP_A_REC: begin
				tgt_q   <= b_q;
				tlen_q  <= len_rd;
				tnext_q <= next_rd;
				tprev_q <= prev_rd;
				blen_q  <= len_rd;
			end
			OP_A_SPLIT: begin
				r_q    <= b_q + need_q[GRAN_W-1:0];
				tgt_q  <= b_q + need_q[GRAN_W-1:0];
				tlen_q <= rem_len;
			end
			OP_A_FIN: begin
				res_status_q <= ST_OK;
				res_off_q    <= b_q;
				res_len_q    <= need_q;
			end
			OP_F_CHK: begin
				blen_q       <= len_rd;
				l_q          <= left_rd;
				r_q          <= chk_end[GRAN_W-1:0];
				res_status_q <= ST_BAD_FREE;
				res_off_q    <= '0;
				res_len_q    <= '0;
			end
			OP_F_RREC: begin
				tgt_q   <= r_q;
				tlen_q  <= len_rd;
				tnext_q <= next_rd;
				tprev_q <= prev_rd;
			end
			OP_F_RMRG: blen_q <= mrg_len;
			OP_F_LREC: begin
				tgt_q   <= l_q;
				tlen_q  <= len_rd;
				tnext_q <= next_rd;
				tprev_q <= prev_rd;
			end
			OP_F_LMRG: begin
				blen_q <= mrg_len;
				b_q    <= l_q;
			end
			OP_F_FINAL: begin
				tgt_q        <= b_q;
				tlen_q       <= blen_q;
				res_status_q <= ST_OK;
				res_off_q    <= b_q;
				res_len_q    <= blen_q;
			end
			OP_OUT: begin
				rsp_q.status         <= res_status_q;
				rsp_q.block_offset   <= res_off_q;
				rsp_q.block_granules <= res_len_q;
				rsp_q.free_granules  <= total_q;
			end
			default: ;
		endcase
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

/* sv/best_fit_granule_allocator_core.sv */
// Throughput: one request at a time, next one taken the cycle after the result is loaded.
// A result beat waits in an output register while the next request is taken.
// After reset a sweep over every granule clears the block-start memory; no request is taken meanwhile.
// Reset: granule_log2 = 8, whole pool free as one block at granule zero.
`timescale 1ns / 1ps
module best_fit_granule_allocator_core import bfga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	bfga_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bfga_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

/* bench/best_fit_granule_allocator_core_test.sv */
// Self-checking bench for the best-fit granule allocator core.
`timescale 1ns / 1ps
module best_fit_granule_allocator_core_test;
	import bfga_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;

	always #4 clk = ~clk;

	best_fit_granule_allocator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// pool shadow
	localparam int NONE = GRANULES;
	int unsigned blen[GRANULES];
	bit          starts[GRANULES];
	bit          busy[GRANULES];
	int unsigned leftn[GRANULES];
	int unsigned nxt[GRANULES];
	int unsigned prv[GRANULES];
	int unsigned head[GRANULES];
	bit          occ[GRANULES];
	int unsigned pool_free;
	logic [4:0]  glog2;

	rsp_t        pending_rsp[$];
	int unsigned live_blocks[$];
	int          errors = 0;
	int          beats_in = 0, beats_out = 0, n_ok_alloc = 0, n_ok_free = 0;
	int          idle_cycles = 0;
	bit          stall_long = 0;

	task automatic pool_reset();
		for (int i = 0; i < GRANULES; i++) begin
			blen[i] = 0; starts[i] = 0; busy[i] = 0; leftn[i] = 0;
			nxt[i] = NONE; prv[i] = NONE; head[i] = 0; occ[i] = 0;
		end
		blen[0] = GRANULES; starts[0] = 1;
		occ[GRANULES-1] = 1; head[GRANULES-1] = 0;
		pool_free = GRANULES;
		glog2 = LOG2_RST;
	endtask

	function automatic void list_remove(int unsigned b);
		int unsigned c, n, p;
		c = blen[b] - 1; n = nxt[b]; p = prv[b];
		if (n < NONE) prv[n] = p;
		if (p < NONE) nxt[p] = n;
		if (occ[c] && head[c] == b) begin
			head[c] = n;
			if (n >= NONE) occ[c] = 0;
		end
		nxt[b] = NONE; prv[b] = NONE;
	endfunction

	function automatic void list_push(int unsigned b);
		int unsigned c;
		c = blen[b] - 1;
		prv[b] = NONE;
		if (occ[c]) begin
			nxt[b] = head[c];
			prv[head[c]] = b;
		end else begin
			nxt[b] = NONE;
		end
		head[c] = b; occ[c] = 1;
	endfunction

	function automatic rsp_t allocator_step(req_t r);
		rsp_t o;
		longint unsigned need64;
		int unsigned need, c, b, bl, rr, nx, l;
		o = '0;
		if (r.action != ACT_FREE) begin
			need64 = (longint'(r.request_bytes) + ((64'd1 << glog2) - 1)) >> glog2;
			if (r.request_bytes == 0 || need64 > GRANULES) begin
				o.status = ST_BAD_SIZE;
			end else begin
				need = 32'(need64);
				c = need - 1;
				while (c < GRANULES && !occ[c]) c++;
				if (c >= GRANULES) begin
					o.status = ST_NO_FIT;
				end else begin
					b = head[c]; bl = blen[b];
					list_remove(b);
					if (bl > need) begin
						rr = b + need; nx = b + bl;
						blen[rr] = bl - need; starts[rr] = 1; busy[rr] = 0;
						leftn[rr] = b;
						if (nx < GRANULES) leftn[nx] = rr;
						blen[b] = need;
						list_push(rr);
					end
					busy[b] = 1;
					pool_free -= need;
					o.status = ST_OK; o.block_offset = 12'(b); o.block_granules = 13'(need);
					live_blocks.push_back(b);
				end
			end
		end else begin
			b = r.release_offset;
			if (!starts[b] || !busy[b]) begin
				o.status = ST_BAD_FREE;
			end else begin
				bl = blen[b]; rr = b + bl;
				busy[b] = 0; pool_free += bl;
				if (rr < GRANULES && !busy[rr]) begin
					list_remove(rr);
					bl += blen[rr];
					starts[rr] = 0; blen[rr] = 0; blen[b] = bl;
					rr = b + bl;
					if (rr < GRANULES) leftn[rr] = b;
				end
				if (b > 0) begin
					l = leftn[b];
					if (l < GRANULES && !busy[l]) begin
						list_remove(l);
						bl += blen[l];
						starts[b] = 0; blen[b] = 0; blen[l] = bl;
						b = l; rr = b + bl;
						if (rr < GRANULES) leftn[rr] = b;
					end
				end
				list_push(b);
				o.status = ST_OK; o.block_offset = 12'(b); o.block_granules = 13'(bl);
			end
		end
		o.free_granules = 13'(pool_free);
		return o;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// valid stays up across a zero-length gap; it drops only before an idle stretch
	task automatic send_request(req_t r);
		rsp_t e;
		int   gap;
		gap = gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		e = allocator_step(r);
		if (e.status == ST_OK) begin
			if (r.action == ACT_FREE) n_ok_free++; else n_ok_alloc++;
		end
		pending_rsp.push_back(e);
		beats_in++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_log2(logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		glog2 = v;
	endtask

	function automatic req_t alloc_req(logic [31:0] bytes);
		req_t r;
		r = '0;
		r.request_bytes = bytes;
		r.release_offset = 12'($urandom);
		return r;
	endfunction

	function automatic req_t free_req(logic [11:0] off);
		req_t r;
		r.action = ACT_FREE;
		r.request_bytes = $urandom;
		r.release_offset = off;
		return r;
	endfunction

	// free a random live block, or occasionally a bogus offset
	task automatic free_some();
		int i;
		if (live_blocks.size() == 0 || $urandom_range(0, 9) == 0) begin
			send_request(free_req(12'($urandom)));
		end else begin
			i = $urandom_range(0, live_blocks.size() - 1);
			send_request(free_req(12'(live_blocks[i])));
			live_blocks.delete(i);
		end
	endtask

	task automatic test_directed();
		write_log2(5'd8);
		send_request(alloc_req(32'd0));
		send_request(alloc_req(32'hFFFF_FFFF));
		send_request(alloc_req(32'd1));
		send_request(alloc_req(32'd256));
		send_request(alloc_req(32'd257));
		send_request(alloc_req(32'h0010_0000));
		send_request(free_req(12'd0));
		send_request(free_req(12'd0));
		send_request(free_req(12'd4095));
		send_request(free_req(12'd2));
		send_request(free_req(12'd1));
		send_request(alloc_req(32'd768));
		live_blocks.delete();
		send_request(free_req(12'd0));
		send_request(free_req(12'd3));
		drain();
		write_log2(5'd0);
		send_request(alloc_req(32'd4096));
		send_request(alloc_req(32'd1));
		send_request(free_req(12'd0));
		send_request(alloc_req(32'd4097));
		send_request(alloc_req(32'd4095));
		send_request(alloc_req(32'd1));
		send_request(alloc_req(32'd1));
		send_request(free_req(12'd4095));
		send_request(free_req(12'd0));
		drain();
	endtask

	task automatic test_register_extremes();
		write_log2(5'd31);
		send_request(alloc_req(32'hFFFF_FFFF));
		send_request(alloc_req(32'd1));
		drain();
		write_log2(5'd16);
		send_request(alloc_req(32'hFFFF_FFFF));
		send_request(alloc_req(32'h1000_0001));
		drain();
	endtask

	// random churn of allocates and frees under one granule size
	task automatic test_random_phase(logic [4:0] lg, int count);
		int sh;
		write_log2(lg);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 50) begin
				sh = lg + $urandom_range(0, 7);
				if ($urandom_range(0, 19) == 0)
					send_request(alloc_req($urandom));
				else
					send_request(alloc_req(($urandom_range(1, 1 << 12) << lg) >> $urandom_range(0, 4)
						>> (sh > lg ? 0 : 0)));
			end else begin
				free_some();
			end
		end
		drain();
	endtask

	task automatic test_quiet_pauses();
		write_log2(5'd4);
		for (int k = 0; k < 60; k++) begin
			send_request(alloc_req($urandom_range(1, 200)));
			if (k % 10 == 9) drain();
			free_some();
		end
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_valid && rsp_ready) begin
			beats_out++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result beat %p", rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); errors++;
				end
				if (rsp.block_offset !== e.block_offset) begin
					$error("block_offset exp %0d got %0d", e.block_offset, rsp.block_offset);
					errors++;
				end
				if (rsp.block_granules !== e.block_granules) begin
					$error("block_granules exp %0d got %0d", e.block_granules,
						rsp.block_granules);
					errors++;
				end
				if (rsp.free_granules !== e.free_granules) begin
					$error("free_granules exp %0d got %0d", e.free_granules,
						rsp.free_granules);
					errors++;
				end
			end
		end
	end

	// receiver stalls: mostly ready, bursts of back-pressure
	always @(posedge clk) begin
		int k;
		k = $urandom_range(0, 99);
		if (stall_long) rsp_ready <= (k < 30);
		else rsp_ready <= (k < 75);
		if ($urandom_range(0, 199) == 0) stall_long <= ~stall_long;
	end

	// watchdog; covers the post-reset clearing sweep
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("best_fit_granule_allocator_core_test: FAIL");
			$finish;
		end
	end

	initial begin
		pool_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_extremes();
		test_random_phase(5'd0, 500);
		test_random_phase(5'd8, 500);
		test_quiet_pauses();
		test_random_phase(5'd3, 400);
		$display("covered %0d requests (%0d allocs ok, %0d frees ok), %0d results checked",
			beats_in, n_ok_alloc, n_ok_free, beats_out);
		$display("granule sizes 1B to 2^31B, zero/oversize/no-fit/bad-free cases, stalls");
		if (errors == 0 && pending_rsp.size() == 0)
			$display("best_fit_granule_allocator_core_test: PASS");
		else
			$display("best_fit_granule_allocator_core_test: FAIL");
		$finish;
	end

endmodule
